[rtl/cpp_pkg.sv]
// Package for the closest-point-on-polygon block: sequencer states, datapath
// operation codes, control/status structs and configuration register indexes.
// No dependencies; imported by the top level, sequencer, datapath and bench files.
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

  // Sequencer states: one pass through S_LOAD..S_CMP handles one edge
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_LEN,
    S_DIVINIT,
    S_DIV,
    S_LX,
    S_LY,
    S_DX,
    S_DY,
    S_DSUM,
    S_CMP,
    S_OUT
  } cpp_state_t;

  // Operand pairs fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_VX_WX,
    MUL_VY_WY,
    MUL_VX_VX,
    MUL_VY_VY,
    MUL_VX_T,
    MUL_VY_T,
    MUL_DX_DX,
    MUL_DY_DY
  } cpp_mul_sel_t;

  // Accumulator operation on the registered product
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } cpp_acc_op_t;

  // Which edge is being closed: previous->current or current->first
  typedef enum logic {
    EDGE_OPEN,
    EDGE_CLOSE
  } cpp_edge_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 1'b1;

  // Sequencer to datapath control
  typedef struct packed {
    logic         cap_vtx;
    logic         first_load;
    logic         prev_in;
    logic         prev_cur;
    logic         edge_load;
    cpp_edge_t    edge_sel;
    cpp_mul_sel_t mul_sel;
    cpp_acc_op_t  acc_op;
    logic         dot_load;
    logic         div_init;
    logic         div_step;
    logic         lerp_x;
    logic         lerp_y;
    logic         best_cmp;
    logic         clear;
    logic         out_load;
  } cpp_ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic need_div;
  } cpp_stat_t;

endpackage

`default_nettype wire

[rtl/cpp_vertex_if.sv]
// Valid/ready channel that carries one polygon vertex per transfer.
// Standalone; used by the top level of the closest-point block.
`timescale 1ns / 1ps
`default_nettype none

interface cpp_vertex_if #(
  parameter int COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

`default_nettype wire

[rtl/cpp_point_if.sv]
// Valid/ready channel that carries one closest boundary point per transfer.
// Standalone; used by the top level of the closest-point block.
`timescale 1ns / 1ps
`default_nettype none

interface cpp_point_if #(
  parameter int COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] closest_x;
  logic signed [COORD_WIDTH-1:0] closest_y;

  modport source (output valid, output closest_x, output closest_y, input ready);
  modport sink   (input valid, input closest_x, input closest_y, output ready);
endinterface

`default_nettype wire

[rtl/closest_point_on_polygon.sv]
// Closest point on a closed polygon boundary: vertices stream in one per
// transfer on vertices, the closest point to the configured centre leaves on
// closest. Load the centre through cfg_write/cfg_index/cfg_data while idle
// (index 0 centre x, index 1 centre y, signed Q15.8).
// Each accepted vertex after the first closes an edge; the vertex with
// last_vertex set also closes the edge back to the first vertex and then
// produces one result. Every edge runs through one shared multiplier and
// accumulator under the sequencer, plus the steps of the restoring divider
// when the projection falls strictly inside the edge. The first vertex of
// a polygon is only stored, a middle one adds its edge, and the last one
// adds its own edge if any, the closing edge and the result register load.
// vertices.ready is low while an edge is in work. The result register
// lets a new polygon start while a result waits; a stalled receiver holds
// the block only when the next result is ready to load. Reset clears the
// centre to zero, empties the vertex store and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_polygon import cpp_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  cpp_vertex_if.sink             vertices,
  cpp_point_if.source            closest
);

  logic signed [COORD_WIDTH-1:0] center_x, center_y;
  logic signed [COORD_WIDTH-1:0] best_x, best_y;
  cpp_ctrl_t                     ctrl;
  cpp_stat_t                     stat;
  logic                          out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !closest.valid || closest.ready;

  cpp_seq #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertices.valid),
    .in_last  (vertices.last_vertex),
    .in_ready (vertices.ready),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  cpp_dp #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .in_x     (vertices.vertex_x),
    .in_y     (vertices.vertex_y),
    .center_x (center_x),
    .center_y (center_y),
    .best_x   (best_x),
    .best_y   (best_y)
  );

  // Result register: load on the closing edge, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      closest.valid <= 1'b0;
    end else if (ctrl.out_load) begin
      closest.valid <= 1'b1;
    end else if (closest.ready) begin
      closest.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      closest.closest_x <= best_x;
      closest.closest_y <= best_y;
    end
  end

endmodule

`default_nettype wire

[rtl/cpp_seq.sv]
// Sequencer of the closest-point block: walks each edge through the shared
// multiplier, accumulator and divider steps. Depends on cpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpp_seq import cpp_pkg::*; #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  logic      out_free,
  input  cpp_stat_t stat,
  output cpp_ctrl_t ctrl
);

  localparam int CNT_W = $clog2(PARAM_FRAC_BITS);

  cpp_state_t       state;
  cpp_state_t       state_next;
  logic             have_first;
  logic             last_reg;
  cpp_edge_t        edge_sel;
  logic [CNT_W-1:0] cnt;
  logic             in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (have_first || in_last)) state_next = S_LOAD;
      end
      S_LOAD:    state_next = S_MUL0;
      S_MUL0:    state_next = S_MUL1;
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = S_MUL3;
      S_MUL3:    state_next = S_LEN;
      S_LEN:     state_next = S_DIVINIT;
      S_DIVINIT: state_next = stat.need_div ? S_DIV : S_LX;
      S_DIV: begin
        if (cnt == '0) state_next = S_LX;
      end
      S_LX:      state_next = S_LY;
      S_LY:      state_next = S_DX;
      S_DX:      state_next = S_DY;
      S_DY:      state_next = S_DSUM;
      S_DSUM:    state_next = S_CMP;
      S_CMP: begin
        if (edge_sel == EDGE_CLOSE)  state_next = S_OUT;
        else if (last_reg)           state_next = S_LOAD;
        else                         state_next = S_IDLE;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl          = '0;
    ctrl.edge_sel = edge_sel;
    ctrl.mul_sel  = MUL_VX_WX;
    ctrl.acc_op   = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.cap_vtx = 1'b1;
          if (!have_first) begin
            ctrl.first_load = 1'b1;
            ctrl.prev_in    = !in_last;
          end
        end
      end
      S_LOAD:    ctrl.edge_load = 1'b1;
      S_MUL0:    ctrl.mul_sel = MUL_VX_WX;
      S_MUL1: begin
        ctrl.mul_sel = MUL_VY_WY;
        ctrl.acc_op  = ACC_LOAD;
      end
      S_MUL2: begin
        ctrl.mul_sel = MUL_VX_VX;
        ctrl.acc_op  = ACC_ADD;
      end
      S_MUL3: begin
        ctrl.mul_sel  = MUL_VY_VY;
        ctrl.acc_op   = ACC_LOAD;
        ctrl.dot_load = 1'b1;
      end
      S_LEN:     ctrl.acc_op = ACC_ADD;
      S_DIVINIT: ctrl.div_init = 1'b1;
      S_DIV:     ctrl.div_step = 1'b1;
      S_LX:      ctrl.mul_sel = MUL_VX_T;
      S_LY: begin
        ctrl.mul_sel = MUL_VY_T;
        ctrl.lerp_x  = 1'b1;
      end
      S_DX: begin
        ctrl.mul_sel = MUL_DX_DX;
        ctrl.lerp_y  = 1'b1;
      end
      S_DY: begin
        ctrl.mul_sel = MUL_DY_DY;
        ctrl.acc_op  = ACC_LOAD;
      end
      S_DSUM:    ctrl.acc_op = ACC_ADD;
      S_CMP: begin
        ctrl.best_cmp = 1'b1;
        ctrl.prev_cur = (edge_sel == EDGE_OPEN);
      end
      S_OUT: begin
        ctrl.out_load = out_free;
        ctrl.clear    = out_free;
      end
      default: ;
    endcase
  end

  // State and polygon bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      have_first <= 1'b0;
      last_reg   <= 1'b0;
      edge_sel   <= EDGE_OPEN;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        have_first <= 1'b1;
        last_reg   <= in_last;
        edge_sel   <= have_first ? EDGE_OPEN : EDGE_CLOSE;
      end
      if (state == S_CMP && edge_sel == EDGE_OPEN && last_reg) edge_sel <= EDGE_CLOSE;
      if (state == S_OUT && out_free) have_first <= 1'b0;
      if (state == S_DIVINIT) cnt <= CNT_W'(PARAM_FRAC_BITS - 1);
      else if (state == S_DIV) cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/cpp_dp.sv]
// Datapath of the closest-point block: vertex store, shared multiplier with
// accumulator, restoring divider step, rounding and best-point compare.
// Depends on cpp_pkg; driven by cpp_seq.
`timescale 1ns / 1ps
`default_nettype none

module cpp_dp import cpp_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cpp_ctrl_t                     ctrl,
  output cpp_stat_t                     stat,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH-1:0] best_x,
  output logic signed [COORD_WIDTH-1:0] best_y
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int EW = CW + 1;                            // edge and offset vectors
  localparam int MW = ((EW > F + 1) ? EW : F + 1) + 1;   // multiplier operands
  localparam int PW = 2 * MW;                            // product
  localparam int AW = 2 * CW + 3;                        // dot, length, distance
  localparam logic [PW-1:0] HALF  = PW'(1 << (F - 1));
  localparam logic [F:0]    T_ONE = {1'b1, {F{1'b0}}};

  logic signed [CW-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic signed [CW-1:0] ax, ay, px, py;
  logic signed [CW-1:0] ea_x, ea_y, eb_x, eb_y;
  logic signed [EW-1:0] vx, vy, wx, wy, dx, dy;
  logic        [EW-1:0] abs_vx, abs_vy;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_full, prod;
  logic signed [AW-1:0] prod_a, acc, dot;
  logic        [AW-1:0] lensq, rem, rem2, best_dist;
  logic        [F:0]    t;
  logic        [PW-1:0] rnd;
  logic        [EW-1:0] q, lbase, lres;
  logic                 lsign;
  logic                 len_zero, dot_pos, dot_ge;

  // Edge endpoints
  always_comb begin
    if (ctrl.edge_sel == EDGE_CLOSE) begin
      ea_x = cur_x;
      ea_y = cur_y;
      eb_x = first_x;
      eb_y = first_y;
    end else begin
      ea_x = prev_x;
      ea_y = prev_y;
      eb_x = cur_x;
      eb_y = cur_y;
    end
  end

  // Vertex store and edge setup
  always_ff @(posedge clk) begin
    if (ctrl.cap_vtx) begin
      cur_x <= in_x;
      cur_y <= in_y;
    end
    if (ctrl.first_load) begin
      first_x <= in_x;
      first_y <= in_y;
    end
    if (ctrl.prev_in) begin
      prev_x <= in_x;
      prev_y <= in_y;
    end else if (ctrl.prev_cur) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (ctrl.edge_load) begin
      ax <= ea_x;
      ay <= ea_y;
      vx <= EW'(eb_x) - EW'(ea_x);
      vy <= EW'(eb_y) - EW'(ea_y);
      wx <= EW'(center_x) - EW'(ea_x);
      wy <= EW'(center_y) - EW'(ea_y);
    end
  end

  assign abs_vx = vx[EW-1] ? $unsigned(-vx) : $unsigned(vx);
  assign abs_vy = vy[EW-1] ? $unsigned(-vy) : $unsigned(vy);
  assign dx     = EW'(px) - EW'(center_x);
  assign dy     = EW'(py) - EW'(center_y);

  // Shared multiplier operand select
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_VX_WX: begin mul_a = MW'(vx);     mul_b = MW'(wx); end
      MUL_VY_WY: begin mul_a = MW'(vy);     mul_b = MW'(wy); end
      MUL_VX_VX: begin mul_a = MW'(vx);     mul_b = MW'(vx); end
      MUL_VY_VY: begin mul_a = MW'(vy);     mul_b = MW'(vy); end
      MUL_VX_T:  begin mul_a = MW'(abs_vx); mul_b = MW'(t);  end
      MUL_VY_T:  begin mul_a = MW'(abs_vy); mul_b = MW'(t);  end
      MUL_DX_DX: begin mul_a = MW'(dx);     mul_b = MW'(dx); end
      MUL_DY_DY: begin mul_a = MW'(dy);     mul_b = MW'(dy); end
      default:   begin mul_a = MW'(vx);     mul_b = MW'(wx); end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod_a   = AW'(prod);

  // Register the product, then accumulate
  always_ff @(posedge clk) begin
    prod <= mul_full;
    unique case (ctrl.acc_op)
      ACC_LOAD: acc <= prod_a;
      ACC_ADD:  acc <= acc + prod_a;
      default:  acc <= acc;
    endcase
    if (ctrl.dot_load) dot <= acc;
  end

  // Clamp decision for the projection parameter; acc holds the squared length
  assign len_zero      = (acc == '0);
  assign dot_pos       = !dot[AW-1] && (dot != '0);
  assign dot_ge        = $unsigned(dot) >= $unsigned(acc);
  assign stat.need_div = !len_zero && dot_pos && !dot_ge;

  // Restoring divider, one quotient bit per step
  assign rem2 = {rem[AW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      lensq <= $unsigned(acc);
      rem   <= $unsigned(dot);
      t     <= (!len_zero && dot_pos && dot_ge) ? T_ONE : '0;
    end else if (ctrl.div_step) begin
      if (rem2 >= lensq) begin
        rem <= rem2 - lensq;
        t   <= {t[F-1:0], 1'b1};
      end else begin
        rem <= rem2;
        t   <= {t[F-1:0], 1'b0};
      end
    end
  end

  // Round |v| * t to nearest and step from the edge start
  assign rnd = $unsigned(prod) + HALF;
  assign q   = rnd[F +: EW];

  always_comb begin
    lsign = ctrl.lerp_y ? vy[EW-1] : vx[EW-1];
    lbase = ctrl.lerp_y ? EW'(ay) : EW'(ax);
    lres  = lsign ? lbase - q : lbase + q;
  end

  always_ff @(posedge clk) begin
    if (ctrl.lerp_x) px <= lres[CW-1:0];
    if (ctrl.lerp_y) py <= lres[CW-1:0];
  end

  // Keep the first strictly smaller distance
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      best_dist <= '1;
    end else if (ctrl.best_cmp && ($unsigned(acc) < best_dist)) begin
      best_dist <= $unsigned(acc);
      best_x    <= px;
      best_y    <= py;
    end
  end

endmodule

`default_nettype wire

[rtl/cpp_checker.sv]
// Port-level checks for closest_point_on_polygon, attached by the bind below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module cpp_port_checks #(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("closest point changed while stalled");

  // A closing vertex always starts edge work
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready after closing vertex");

  // A middle vertex never produces a result right away
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_last |=> !$rose(out_valid))
    else $error("result after a non-closing vertex");

  // Reset leaves the block ready and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind closest_point_on_polygon cpp_port_checks #(
  .COORD_WIDTH(COORD_WIDTH)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vertices.valid),
  .in_ready  (vertices.ready),
  .in_last   (vertices.last_vertex),
  .out_valid (closest.valid),
  .out_ready (closest.ready),
  .out_x     (closest.closest_x),
  .out_y     (closest.closest_y)
);

`default_nettype wire

[bench/cpp_checker.sv]
// Checker for the closest-point-on-polygon block: watches the configuration
// port and both channels, predicts each closest point and compares it.
// Depends on cpp_pkg and the cpp_vertex_if / cpp_point_if interfaces.
`timescale 1ns / 1ps

module cpp_checker import cpp_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  cpp_vertex_if                  vertices,
  cpp_point_if                   closest,
  output int                     errors,
  output int                     pending,
  output int                     points_seen
);

  localparam longint DIST_ALL_ONES = (longint'(1) << 51) - 1;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } point_t;

  // Predicted closest points, oldest first
  point_t closest_due[$];
  point_t want;

  // Shadow of the centre registers and the vertex store
  longint centre_x, centre_y;
  bit     have_start;
  longint start_x, start_y, last_x, last_y;
  longint near_x, near_y, near_dist;
  longint vx_in, vy_in;

  function automatic longint widen(logic [COORD_WIDTH-1:0] v);
    longint r;
    r = $signed(v);
    return r;
  endfunction

  // Move from p along d by t (unsigned Q1.F), rounding halves away from zero
  function automatic longint step_along(longint p, longint d, longint t);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag * t + (longint'(1) << (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;
    if (d < 0)
      return p - q;
    return p + q;
  endfunction

  // Project the centre onto edge a->b and keep the point if strictly nearer
  function automatic void try_edge(longint ax, longint ay, longint bx, longint by);
    longint ex, ey, wx, wy, dot, len_sq, t, rem, px, py, dx, dy, sq_dist;
    ex = bx - ax;
    ey = by - ay;
    wx = centre_x - ax;
    wy = centre_y - ay;
    dot = ex * wx + ey * wy;
    len_sq = ex * ex + ey * ey;
    if (len_sq == 0 || dot <= 0) begin
      t = 0;
    end else if (dot >= len_sq) begin
      t = longint'(1) << PARAM_FRAC_BITS;
    end else begin
      // restoring division, one quotient bit per pass
      rem = dot;
      t = 0;
      for (int i = 0; i < PARAM_FRAC_BITS; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= len_sq) begin
          rem = rem - len_sq;
          t = t | 1;
        end
      end
    end
    px = step_along(ax, ex, t);
    py = step_along(ay, ey, t);
    dx = px - centre_x;
    dy = py - centre_y;
    sq_dist = (dx * dx + dy * dy) & DIST_ALL_ONES;
    if (sq_dist < near_dist) begin
      near_dist = sq_dist;
      near_x = px;
      near_y = py;
    end
  endfunction

  function automatic void empty_store();
    have_start = 1'b0;
    start_x = 0;
    start_y = 0;
    last_x = 0;
    last_y = 0;
    near_x = 0;
    near_y = 0;
    near_dist = DIST_ALL_ONES;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      centre_x = 0;
      centre_y = 0;
      empty_store();
      closest_due.delete();
      pending = 0;
    end else begin
      // Track the centre registers
      if (cfg_write) begin
        if (cfg_index == REG_CENTER_X)
          centre_x = widen(cfg_data);
        else if (cfg_index == REG_CENTER_Y)
          centre_y = widen(cfg_data);
      end

      // Compare a result transfer with the oldest prediction
      if (closest.valid && closest.ready) begin
        if (closest_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected closest point (%0d, %0d), none predicted", $time,
                   $signed(closest.closest_x), $signed(closest.closest_y));
        end else begin
          want = closest_due.pop_front();
          points_seen++;
          if (closest.closest_x !== want.x) begin
            errors++;
            $display("%0t: closest_x expected %0d got %0d", $time,
                     $signed(want.x), $signed(closest.closest_x));
          end
          if (closest.closest_y !== want.y) begin
            errors++;
            $display("%0t: closest_y expected %0d got %0d", $time,
                     $signed(want.y), $signed(closest.closest_y));
          end
        end
      end

      // Advance the prediction on a vertex transfer
      if (vertices.valid && vertices.ready) begin
        vx_in = widen(vertices.vertex_x);
        vy_in = widen(vertices.vertex_y);
        if (!have_start) begin
          have_start = 1'b1;
          start_x = vx_in;
          start_y = vy_in;
        end else begin
          try_edge(last_x, last_y, vx_in, vy_in);
        end
        last_x = vx_in;
        last_y = vy_in;
        if (vertices.last_vertex) begin
          try_edge(vx_in, vy_in, start_x, start_y);
          want.x = near_x[COORD_WIDTH-1:0];
          want.y = near_y[COORD_WIDTH-1:0];
          closest_due.push_back(want);
          empty_store();
        end
      end
      pending = closest_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the closest-point-on-polygon block: clock, reset,
// centre programming and polygon stimulus; cpp_checker gives the failures.
// Depends on cpp_pkg, the channel interfaces, the block and cpp_checker.
`timescale 1ns / 1ps

module tb_top;
  import cpp_pkg::*;

  localparam int COORD_WIDTH     = 24;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int PHASE_VERTICES  = 150;
  localparam int PHASES          = 9;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;
  logic                   gaps_on;

  int errors, pending, points_seen;
  int vertices_sent, polygons_sent, centre_writes, cycles;
  int cx, cy;

  cpp_vertex_if #(.COORD_WIDTH(COORD_WIDTH)) vtx_ch ();
  cpp_point_if  #(.COORD_WIDTH(COORD_WIDTH)) pt_ch ();

  closest_point_on_polygon #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .vertices (vtx_ch),
    .closest  (pt_ch)
  );

  cpp_checker #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vertices   (vtx_ch),
    .closest    (pt_ch),
    .errors     (errors),
    .pending    (pending),
    .points_seen(points_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[closest_point_on_polygon] ERROR");
      $finish;
    end
  end

  // Receiver: stall in random bursts while gaps are enabled
  initial begin
    pt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        pt_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      pt_ch.ready = 1'b1;
    end
  end

  // Offer one vertex and hold it until the transfer; called and left at negedge
  task automatic push_vertex(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                             input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      vtx_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    vtx_ch.valid       = 1'b1;
    vtx_ch.vertex_x    = x;
    vtx_ch.vertex_y    = y;
    vtx_ch.last_vertex = last;
    @(posedge clk);
    while (!vtx_ch.ready) @(posedge clk);
    @(negedge clk);
    vertices_sent++;
    if (last)
      polygons_sent++;
  endtask

  // Drain the block: all predicted points out, then let an open edge finish
  task automatic wait_idle();
    vtx_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_centre(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y);
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = REG_CENTER_X;
    cfg_data  = x;
    @(negedge clk);
    cfg_index = REG_CENTER_Y;
    cfg_data  = y;
    @(negedge clk);
    cfg_write = 1'b0;
    cx = int'($signed(x));
    cy = int'($signed(y));
    centre_writes++;
  endtask

  // Coordinate near the centre, anywhere, or a special value: range end, zero, -1, centre
  function automatic logic [COORD_WIDTH-1:0] pick_coord(input int c, input int kind);
    logic [COORD_WIDTH-1:0] r;
    int span;
    case (kind)
      0: begin
        span = 1 << $urandom_range(2, 14);
        r = COORD_WIDTH'(c + int'($urandom_range(0, span)) - span / 2);
      end
      1: r = COORD_WIDTH'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       r = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
          1:       r = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
          2:       r = '0;
          3:       r = '1;
          default: r = COORD_WIDTH'(c);
        endcase
      end
    endcase
    return r;
  endfunction

  initial begin
    int sides, kind, roll, phase_count;
    logic [COORD_WIDTH-1:0] px, py;

    rst                = 1'b1;
    gaps_on            = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_CENTER_X;
    cfg_data           = '0;
    vtx_ch.valid       = 1'b0;
    vtx_ch.vertex_x    = '0;
    vtx_ch.vertex_y    = '0;
    vtx_ch.last_vertex = 1'b0;
    cx = 0;
    cy = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Single-vertex polygons at the corners of the range
    push_vertex(24'h800000, 24'h7fffff, 1'b1);
    push_vertex(24'h7fffff, 24'h800000, 1'b1);
    // Square around the centre: equal distances, first edge must win
    push_vertex(-24'sd256, -24'sd256, 1'b0);
    push_vertex(24'sd256, -24'sd256, 1'b0);
    push_vertex(24'sd256, 24'sd256, 1'b0);
    push_vertex(-24'sd256, 24'sd256, 1'b1);
    // Repeated vertex gives a zero-length edge
    push_vertex(24'sd500, 24'sd500, 1'b0);
    push_vertex(24'sd500, 24'sd500, 1'b0);
    push_vertex(24'sd700, -24'sd300, 1'b1);
    // Full-range square
    push_vertex(24'h800000, 24'h800000, 1'b0);
    push_vertex(24'h7fffff, 24'h800000, 1'b0);
    push_vertex(24'h7fffff, 24'h7fffff, 1'b0);
    push_vertex(24'h800000, 24'h7fffff, 1'b1);
    // Tiny odd triangle exercises rounding of the projection
    push_vertex(24'sd1, 24'sd0, 1'b0);
    push_vertex(24'sd4, 24'sd7, 1'b0);
    push_vertex(-24'sd3, 24'sd5, 1'b1);
    // Centre moves between edges of one polygon
    push_vertex(24'sd0, 24'sd0, 1'b0);
    push_vertex(24'sd2560, 24'sd0, 1'b0);
    set_centre(24'sd1280, 24'sd1000);
    push_vertex(24'sd2560, 24'sd2560, 1'b0);
    push_vertex(24'sd0, 24'sd2560, 1'b1);

    // Random polygons, one centre setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_centre(24'h7fffff, 24'h800000);
        1:       set_centre(24'h800000, 24'h7fffff);
        2:       set_centre('0, '0);
        default: set_centre(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom));
      endcase
      // Quiet handshakes for the tail of the run
      if (phase >= PHASES - 2)
        gaps_on = 1'b0;
      phase_count = 0;
      while (phase_count < PHASE_VERTICES) begin
        sides = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
        roll = $urandom_range(0, 9);
        kind = (roll < 7) ? 0 : (roll < 9) ? 1 : 2;
        px = pick_coord(cx, kind);
        py = pick_coord(cy, kind);
        for (int i = 0; i < sides; i++) begin
          // Occasionally repeat the previous vertex
          if (i == 0 || $urandom_range(0, 9) != 0) begin
            px = pick_coord(cx, kind);
            py = pick_coord(cy, kind);
          end
          push_vertex(px, py, i == sides - 1);
        end
        phase_count += sides;
      end
    end

    wait_idle();
    $display("Sent %0d vertices in %0d polygons across %0d centre settings.",
             vertices_sent, polygons_sent, centre_writes);
    $display("Compared %0d closest points, %0d mismatches.", points_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("[closest_point_on_polygon] OK");
    end else begin
      $display("[closest_point_on_polygon] ERROR");
    end
    $finish;
  end

endmodule
